// ===== rtl/core/jse_pkg.sv =====
package jse_pkg;

  // default depth of the queue between classifier and serializer
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [7:0] CTRL_LIMIT = 8'h20;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_N = 8'h6E;
  localparam logic [7:0] CH_R = 8'h72;
  localparam logic [7:0] CH_T = 8'h74;
  localparam logic [7:0] CH_U = 8'h75;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_A = 8'h61;

  typedef enum logic [1:0] {
    CMD_BEGIN = 2'd0,
    CMD_DATA  = 2'd1,
    CMD_END   = 2'd2
  } cmd_t;

  // how a queued word expands on the output side
  typedef enum logic [1:0] {
    KIND_PLAIN = 2'd0,  // one byte as is
    KIND_PAIR  = 2'd1,  // backslash then val
    KIND_UNI   = 2'd2   // backslash u 0 0 hex hex of val
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] val;
  } entry_t;

  typedef struct packed {
    logic   push;
    entry_t entry;
  } push_t;

  function automatic logic [2:0] seq_len(kind_t kind);
    logic [2:0] len;
    case (kind)
      KIND_PAIR: len = 3'd2;
      KIND_UNI:  len = 3'd6;
      default:   len = 3'd1;
    endcase
    return len;
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] nib);
    logic [7:0] ch;
    if (nib < 4'd10) ch = CH_ZERO + {4'h0, nib};
    else ch = CH_A + {4'h0, nib} - 8'd10;
    return ch;
  endfunction

  function automatic logic [7:0] seq_byte(entry_t e, logic [2:0] step);
    logic [7:0] ch;
    ch = e.val;
    case (e.kind)
      KIND_PAIR: ch = (step == 3'd0) ? CH_BSLASH : e.val;
      KIND_UNI: begin
        case (step)
          3'd0:    ch = CH_BSLASH;
          3'd1:    ch = CH_U;
          3'd2:    ch = CH_ZERO;
          3'd3:    ch = CH_ZERO;
          3'd4:    ch = hex_char(e.val[7:4]);
          default: ch = hex_char(e.val[3:0]);
        endcase
      end
      default: ch = e.val;
    endcase
    return ch;
  endfunction

endpackage

// ===== rtl/core/json_string_escaper.sv =====
// path: accepted word -> queue slot -> serializer work register -> output register
// throughput: one input word per cycle for bytes that pass through unchanged
//   while out_stall is low; a two-char or \u00xx escape holds the serializer,
//   which emits one byte per cycle when not stalled; the queue absorbs short bursts
// reset: synchronous active-low rst_n empties the queue, the serializer and
//   the output register; no clearing pass, ready right after reset
module json_string_escaper import jse_pkg::*; #(
  parameter int unsigned QDEPTH = QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  // input channel: one command word per handshake
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_cmd,
  input  logic [7:0] in_data_byte,
  // output channel: one escaped text byte per word
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_run_last
);

  push_t  cls_req;   // classified word from the front
  push_t  q_wr;      // gated by the input handshake
  entry_t q_head;
  logic   q_full;
  logic   q_valid;
  logic   q_pop;

  // front: decode command and byte into an escape kind
  jse_classify u_classify (
    .in_cmd       (in_cmd),
    .in_data_byte (in_data_byte),
    .req          (cls_req)
  );

  // stall only on a full queue, never on in_valid
  assign in_stall = q_full;

  // unused command words are accepted and dropped here
  always_comb begin
    q_wr = cls_req;
    q_wr.push = cls_req.push && in_valid;
  end

  // queue decouples input acceptance from output expansion
  jse_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr       (q_wr),
    .full     (q_full),
    .rd_valid (q_valid),
    .rd_entry (q_head),
    .rd_pop   (q_pop)
  );

  // back: expand each word into its byte sequence, registered output
  jse_serializer u_serializer (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (q_valid),
    .q_entry      (q_head),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .out_run_last (out_run_last)
  );

endmodule

// ===== rtl/core/jse_classify.sv =====
module jse_classify import jse_pkg::*; (
  input  logic [1:0] in_cmd,
  input  logic [7:0] in_data_byte,
  output push_t      req
);

  always_comb begin
    req.push = 1'b0;
    req.entry.kind = KIND_PLAIN;
    req.entry.val = in_data_byte;
    unique case (cmd_t'(in_cmd))
      CMD_BEGIN, CMD_END: begin
        req.push = 1'b1;
        req.entry.val = CH_QUOTE;
      end
      CMD_DATA: begin
        req.push = 1'b1;
        case (in_data_byte) inside
          CH_QUOTE, CH_BSLASH: req.entry.kind = KIND_PAIR;
          CH_LF: begin
            req.entry.kind = KIND_PAIR;
            req.entry.val = CH_N;
          end
          CH_CR: begin
            req.entry.kind = KIND_PAIR;
            req.entry.val = CH_R;
          end
          CH_TAB: begin
            req.entry.kind = KIND_PAIR;
            req.entry.val = CH_T;
          end
          default: begin
            if (in_data_byte < CTRL_LIMIT) req.entry.kind = KIND_UNI;
          end
        endcase
      end
      default: req.push = 1'b0;  // unused command, no output
    endcase
  end

endmodule

// ===== rtl/core/jse_queue.sv =====
module jse_queue import jse_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic   clk,
  input  logic   rst_n,
  input  push_t  wr,
  output logic   full,
  output logic   rd_valid,
  output entry_t rd_entry,
  input  logic   rd_pop
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [PW-1:0] LAST_C = PW'(DEPTH - 1);

  entry_t        slot_r [DEPTH];
  logic [PW-1:0] wptr_r, wptr_nxt;
  logic [PW-1:0] rptr_r, rptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full = (cnt_r == DEPTH_C);
  assign rd_valid = (cnt_r != '0);
  assign rd_entry = slot_r[rptr_r];
  assign do_push = wr.push && !full;
  assign do_pop = rd_pop && rd_valid;

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt = cnt_r;
    if (do_push) wptr_nxt = (wptr_r == LAST_C) ? '0 : wptr_r + 1'b1;
    if (do_pop) rptr_nxt = (rptr_r == LAST_C) ? '0 : rptr_r + 1'b1;
    if (do_push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    else if (do_pop && !do_push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wptr_r] <= wr.entry;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= DEPTH_C) else $error("queue count overflow");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    do_pop |=> (cnt_r == $past(cnt_r) - 1'b1) || $past(do_push))
    else $error("queue count lost a pop");

  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> cnt_r == $past(cnt_r) + 1'b1)
    else $error("queue count lost a push");

endmodule

// ===== rtl/core/jse_serializer.sv =====
module jse_serializer import jse_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  input  entry_t     q_entry,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_run_last
);

  entry_t     work_r, work_nxt;
  logic       work_valid_r, work_valid_nxt;
  logic [2:0] step_r, step_nxt;
  logic       ov_r, ov_nxt;
  logic [7:0] ob_r, ob_nxt;
  logic       ol_r, ol_nxt;
  logic       advance, last;
  logic [7:0] cur_byte;

  assign cur_byte = seq_byte(work_r, step_r);
  assign last = (step_r == seq_len(work_r.kind) - 3'd1);
  assign advance = work_valid_r && (!ov_r || !out_stall);
  assign q_pop = q_valid && (!work_valid_r || (advance && last));

  always_comb begin
    work_nxt = work_r;
    work_valid_nxt = work_valid_r;
    step_nxt = step_r;
    ov_nxt = ov_r;
    ob_nxt = ob_r;
    ol_nxt = ol_r;
    if (!out_stall) ov_nxt = 1'b0;
    if (advance) begin
      ov_nxt = 1'b1;
      ob_nxt = cur_byte;
      ol_nxt = last;
      if (last) work_valid_nxt = 1'b0;
      else step_nxt = step_r + 3'd1;
    end
    if (q_pop) begin
      work_nxt = q_entry;
      work_valid_nxt = 1'b1;
      step_nxt = 3'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      work_valid_r <= 1'b0;
      ov_r <= 1'b0;
      step_r <= 3'd0;
    end else begin
      work_valid_r <= work_valid_nxt;
      ov_r <= ov_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    work_r <= work_nxt;
    ob_r <= ob_nxt;
    ol_r <= ol_nxt;
  end

  assign out_valid = ov_r;
  assign out_byte = ob_r;
  assign out_run_last = ol_r;

  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    work_valid_r |-> step_r < seq_len(work_r.kind))
    else $error("escape step past end of sequence");

  a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && out_stall && work_valid_r) |=> $stable(step_r) && work_valid_r)
    else $error("sequence advanced under output stall");

  a_new_word: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> work_valid_r && step_r == 3'd0)
    else $error("popped word not loaded at first step");

endmodule

// ===== test/json_string_escaper_test.sv =====
module json_string_escaper_test;
  import jse_pkg::*;

  // the unused command code: the block drops the word and emits nothing
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // idle cycles after the owed text has drained, so that a stray extra byte
  // still shows up at the checker
  localparam int DRAIN_CYCLES = 40;
  localparam int DRAIN_LIMIT = 20000;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } text_byte_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] in_cmd = CMD_BEGIN;
  logic [7:0] in_data_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       out_run_last;

  // escaped text still owed by the block, oldest byte first
  text_byte_t pending_text[$];
  int         errors = 0;

  // sender burst control
  int         burst_left = 0;
  bit         gaps_on = 1'b1;

  // receiver stall pattern state
  int         stall_mode = 0;
  int         stall_run = 0;
  int         stall_tick = 0;

  json_string_escaper DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_cmd      (in_cmd),
    .in_data_byte(in_data_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .out_run_last(out_run_last)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // safety net in case the handshake locks up
  initial begin
    #400000;
    $display("RESULT: ERROR");
    $finish;
  end

  // lower-case hex digit of one nibble
  function automatic logic [7:0] hex_digit(logic [3:0] nib);
    logic [7:0] ch;
    if (nib < 4'd10) ch = CH_ZERO + {4'h0, nib};
    else ch = CH_A + {4'h0, nib} - 8'd10;
    return ch;
  endfunction

  // work out the escaped text for one accepted word and queue it up
  task automatic escape_word(input logic [1:0] cmd, input logic [7:0] b);
    logic [7:0] seq[6];
    int n;
    text_byte_t t;
    n = 0;
    case (cmd)
      CMD_BEGIN, CMD_END: begin
        // data byte is a don't-care on begin and end
        seq[0] = CH_QUOTE;
        n = 1;
      end
      CMD_DATA: begin
        seq[0] = CH_BSLASH;
        if (b == CH_QUOTE || b == CH_BSLASH) begin
          seq[1] = b;
          n = 2;
        end else if (b == CH_LF) begin
          seq[1] = CH_N;
          n = 2;
        end else if (b == CH_CR) begin
          seq[1] = CH_R;
          n = 2;
        end else if (b == CH_TAB) begin
          seq[1] = CH_T;
          n = 2;
        end else if (b < CTRL_LIMIT) begin
          // backspace and form feed land here too, no short form for them
          seq[1] = CH_U;
          seq[2] = CH_ZERO;
          seq[3] = CH_ZERO;
          seq[4] = hex_digit(b[7:4]);
          seq[5] = hex_digit(b[3:0]);
          n = 6;
        end else begin
          // everything from space upward, 0x7f and high bytes included
          seq[0] = b;
          n = 1;
        end
      end
      default: n = 0;
    endcase
    for (int k = 0; k < n; k++) begin
      t.ch = seq[k];
      t.last = (k == n - 1);
      pending_text.push_back(t);
    end
  endtask

  // drive one word at the falling edge, hold it until the block takes it,
  // then record what it should produce; gaps fall between bursts
  task automatic send_word(input logic [1:0] cmd, input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gaps_on && gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        in_cmd <= 2'($urandom);
        in_data_byte <= 8'($urandom);
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_data_byte <= b;
    do @(posedge clk); while (in_stall === 1'b1);
    escape_word(cmd, b);
  endtask

  // pick a string byte, leaning on the interesting classes
  function automatic logic [7:0] pick_string_byte();
    logic [7:0] b;
    case ($urandom_range(0, 9))
      0, 1, 2: b = 8'($urandom_range(8'h20, 8'h7e));
      3: begin
        case ($urandom_range(0, 4))
          0: b = CH_QUOTE;
          1: b = CH_BSLASH;
          2: b = CH_LF;
          3: b = CH_CR;
          default: b = CH_TAB;
        endcase
      end
      4, 5: b = 8'($urandom_range(0, 8'h1f));
      6: b = 8'($urandom_range(8'h7f, 8'hff));
      default: b = 8'($urandom);
    endcase
    return b;
  endfunction

  // extremes of the byte range, every command, every escape class
  task automatic test_directed();
    logic [7:0] corner[$];
    gaps_on = 1'b0;
    corner = '{8'h00, 8'h1f, 8'h20, 8'hff, CH_QUOTE, CH_BSLASH, CH_LF, CH_CR,
               CH_TAB, 8'h08, 8'h0c, 8'h7f, 8'h80, 8'h41, 8'h2f, 8'h1a};
    send_word(CMD_BEGIN, 8'hff);
    foreach (corner[i]) send_word(CMD_DATA, corner[i]);
    send_word(CMD_END, 8'h5a);
    // unused command with bytes that would otherwise escape
    send_word(CMD_UNUSED, CH_LF);
    send_word(CMD_UNUSED, 8'hff);
    send_word(CMD_BEGIN, 8'h00);
    send_word(CMD_END, CH_QUOTE);
    gaps_on = 1'b1;
  endtask

  // well-formed strings with random content
  task automatic test_random_strings(input int words);
    int sent;
    int len;
    sent = 0;
    while (sent < words) begin
      len = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 12);
      send_word(CMD_BEGIN, 8'($urandom));
      repeat (len) send_word(CMD_DATA, pick_string_byte());
      send_word(CMD_END, 8'($urandom));
      sent += len + 2;
    end
  endtask

  // back-to-back control bytes, mostly \u00xx escapes, with no sender gaps to fill the queue
  task automatic test_escape_burst(input int words);
    gaps_on = 1'b0;
    send_word(CMD_BEGIN, 8'h00);
    repeat (words) send_word(CMD_DATA, 8'($urandom_range(0, 8'h1f)));
    send_word(CMD_END, 8'h00);
    gaps_on = 1'b1;
  endtask

  // fully random words, broken strings and the unused command mixed in
  task automatic test_noise(input int words);
    repeat (words) send_word(2'($urandom), 8'($urandom));
  endtask

  // receiver stall pattern: the mode is redrawn at random on a stall_tick period among
  // no stall, light random stall, long stall runs and an alternating stall
  always @(negedge clk) begin
    stall_tick++;
    if (stall_tick % 64 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: begin
        if (stall_run > 0) begin
          stall_run--;
          out_stall <= 1'b1;
        end else if ($urandom_range(0, 4) == 0) begin
          stall_run = $urandom_range(1, 7);
          out_stall <= 1'b1;
        end else begin
          out_stall <= 1'b0;
        end
      end
      default: out_stall <= stall_tick[0];
    endcase
  end

  // result checker: every accepted output word against the oldest owed byte
  always @(posedge clk) begin
    text_byte_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_text.size() == 0) begin
        $display("%0t: unexpected output word byte %h run_last %b",
                 $time, out_byte, out_run_last);
        errors++;
      end else begin
        want = pending_text.pop_front();
        if (out_byte !== want.ch) begin
          $display("%0t: out_byte mismatch expected %h actual %h",
                   $time, want.ch, out_byte);
          errors++;
        end
        if (out_run_last !== want.last) begin
          $display("%0t: out_run_last mismatch expected %b actual %b",
                   $time, want.last, out_run_last);
          errors++;
        end
      end
    end
  end

  initial begin
    int waited;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random_strings(140);
    test_escape_burst(20);
    test_noise(40);

    @(negedge clk);
    in_valid <= 1'b0;

    // let the block finish what it owes, then a quiet tail
    waited = 0;
    while (pending_text.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (pending_text.size() != 0) begin
      $display("%0t: %0d expected bytes never arrived", $time, pending_text.size());
      errors++;
    end
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
